[rtl/tlvp_pkg.sv]
// ----------------------------------------------------------------------------
// tlvp_pkg
// Types and constants shared by the attribute stream parser modules.
// ----------------------------------------------------------------------------
package tlvp_pkg;

  localparam logic [15:0] FLAGS_ID = 16'd6;

  // Result kinds as they leave the block
  localparam logic [1:0] KIND_VALUE  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_FLAGS  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef enum logic [2:0] {
    PH_ID_LO  = 3'd0,
    PH_ID_HI  = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_END    = 2'd1,
    OP_VALUE  = 2'd2
  } op_t;

  // Request passed from the front parser to the back end
  typedef struct packed {
    op_t         op;
    logic        clear_flags;   // a new list started since the last request
    logic        known;
    logic        last;
    logic [15:0] attr_id;
    logic [7:0]  value_byte;
    logic [15:0] byte_offset;
    logic [15:0] record_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] attr_id;
    logic [7:0]  value_byte;
    logic [15:0] byte_offset;
    logic        last;
    logic [15:0] record_length;
    logic        known;
    logic [31:0] flags_word;
  } result_t;

endpackage

[rtl/tlvp_fifo.sv]
// ----------------------------------------------------------------------------
// tlvp_fifo
// Two-entry request queue between the parser front and the back end.
// ----------------------------------------------------------------------------
module tlvp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

[rtl/tlvp_front.sv]
// ----------------------------------------------------------------------------
// tlvp_front
// Byte phase machine: assembles id and length, counts value bytes, keeps the
// length table and issues one request per byte that produces a result.
// ----------------------------------------------------------------------------
module tlvp_front
  import tlvp_pkg::*;
#(
  parameter int KNOWN_IDS = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       start_list,
  output logic       req_valid,
  input  logic       req_ready,
  output req_t       req
);

  localparam int IDX_W = $clog2(KNOWN_IDS);

  phase_t      phase, phase_next;
  logic [15:0] current_id, current_id_next;
  logic [15:0] current_length, current_length_next;
  logic [15:0] value_count, value_count_next;
  logic        list_done, list_done_next;
  logic        pend_clear, pend_clear_next;
  logic [15:0] length_table [KNOWN_IDS];

  logic        accept;
  phase_t      ph_eff;
  logic [15:0] id_eff;
  logic [15:0] len_eff;
  logic [15:0] cnt_eff;
  logic        done_eff;
  logic [15:0] len_full;
  logic        known;
  logic        last;
  logic        tbl_we;

  assign in_ready = req_ready;
  assign accept   = in_valid && in_ready;

  // Start of a new list clears state before the byte is parsed
  assign ph_eff   = start_list ? PH_ID_LO : phase;
  assign id_eff   = start_list ? 16'd0 : current_id;
  assign len_eff  = start_list ? 16'd0 : current_length;
  assign cnt_eff  = start_list ? 16'd0 : value_count;
  assign done_eff = start_list ? 1'b0 : list_done;
  assign len_full = {in_byte, len_eff[7:0]};
  assign known    = (id_eff != 16'd0) && (id_eff < 16'(KNOWN_IDS));
  assign last     = ({1'b0, cnt_eff} + 17'd1) >= {1'b0, len_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID_LO;
      current_id     <= 16'd0;
      current_length <= 16'd0;
      value_count    <= 16'd0;
      list_done      <= 1'b0;
      pend_clear     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      current_id     <= current_id_next;
      current_length <= current_length_next;
      value_count    <= value_count_next;
      list_done      <= list_done_next;
      pend_clear     <= pend_clear_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KNOWN_IDS; i++) begin
      if (rst || (accept && start_list)) begin
        length_table[i] <= 16'd0;
      end else if (tbl_we && (id_eff[IDX_W-1:0] == IDX_W'(i))) begin
        length_table[i] <= len_full;
      end
    end
  end

  always_comb begin
    phase_next          = ph_eff;
    current_id_next     = id_eff;
    current_length_next = len_eff;
    value_count_next    = cnt_eff;
    list_done_next      = done_eff;
    tbl_we              = 1'b0;
    req_valid           = 1'b0;
    req                 = '0;
    req.attr_id         = id_eff;
    req.record_length   = len_eff;
    req.clear_flags     = pend_clear || start_list;
    if (!done_eff) begin
      unique case (ph_eff)
        PH_ID_HI: begin
          current_id_next = {in_byte, id_eff[7:0]};
          phase_next      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          current_length_next = {8'd0, in_byte};
          phase_next          = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          current_length_next = len_full;
          value_count_next    = 16'd0;
          req.record_length   = len_full;
          req_valid           = 1'b1;
          if (id_eff == 16'd0) begin
            list_done_next = 1'b1;
            phase_next     = PH_ID_LO;
            req.op         = OP_END;
          end else begin
            tbl_we     = known && accept;
            phase_next = (len_full != 16'd0) ? PH_VALUE : PH_ID_LO;
            req.op     = OP_HEADER;
            req.known  = known;
          end
        end
        PH_VALUE: begin
          value_count_next = cnt_eff + 16'd1;
          if (last) phase_next = PH_ID_LO;
          req_valid       = known;
          req.op          = OP_VALUE;
          req.known       = 1'b1;
          req.last        = last;
          req.value_byte  = in_byte;
          req.byte_offset = cnt_eff;
        end
        default: begin
          current_id_next = {8'd0, in_byte};
          phase_next      = PH_ID_HI;
        end
      endcase
    end
    req_valid       = req_valid && in_valid;
    // hold a pending flags clear until a request carries it
    pend_clear_next = (pend_clear || start_list) && !req_valid;
  end

endmodule

[rtl/tlvp_back.sv]
// ----------------------------------------------------------------------------
// tlvp_back
// Executes parser requests: maintains the flags word, selects the result
// kind and holds the result in an output register.
// ----------------------------------------------------------------------------
module tlvp_back
  import tlvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  req_t    req,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  logic [31:0] flags_value;
  logic [31:0] flags_next;
  result_t     res_next;
  logic        take;
  logic        is_flags;

  assign req_ready = !res_valid || res_ready;
  assign take      = req_valid && req_ready;
  assign is_flags  = (req.attr_id == FLAGS_ID);

  always_comb begin
    flags_next             = req.clear_flags ? 32'd0 : flags_value;
    res_next               = '0;
    res_next.attr_id       = req.attr_id;
    res_next.record_length = req.record_length;
    res_next.known         = req.known;
    unique case (req.op)
      OP_HEADER: begin
        if (is_flags && (req.record_length != 16'd0)) flags_next = 32'd0;
        res_next.kind = KIND_HEADER;
      end
      OP_END: begin
        res_next.kind = KIND_END;
      end
      OP_VALUE: begin
        res_next.kind        = KIND_VALUE;
        res_next.value_byte  = req.value_byte;
        res_next.byte_offset = req.byte_offset;
        res_next.last        = req.last;
        if (is_flags && (req.byte_offset < 16'd4)) begin
          // merge byte into its little-endian lane
          unique case (req.byte_offset[1:0])
            2'd0: flags_next[7:0]   = flags_next[7:0]   | req.value_byte;
            2'd1: flags_next[15:8]  = flags_next[15:8]  | req.value_byte;
            2'd2: flags_next[23:16] = flags_next[23:16] | req.value_byte;
            default: flags_next[31:24] = flags_next[31:24] | req.value_byte;
          endcase
          if ((req.byte_offset[1:0] == 2'd3) || req.last) res_next.kind = KIND_FLAGS;
        end
      end
      default: begin
        res_next.kind = KIND_HEADER;
      end
    endcase
    res_next.flags_word = flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      flags_value <= 32'd0;
    end else begin
      if (take) begin
        res_valid   <= 1'b1;
        flags_value <= flags_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

endmodule

[rtl/tlv_attribute_stream_parser.sv]
// ----------------------------------------------------------------------------
// tlv_attribute_stream_parser
// Parses an id / length / value attribute list one byte per cycle when not
// stalled, and emits headers, value bytes, the flags word and the end-of-list mark.
//
//   channel  dir  tdata                                   tuser        tlast
//   s_axis   in   in_byte                                 start_list   -
//   m_axis   out  id, byte, offset, length, known, flags  kind         last_of_record
//
// One byte is accepted per cycle while s_axis_tready is high; each byte yields
// at most one result. A request leaves the front parser in the cycle the byte
// is taken and reaches the output register through a two-entry queue.
// Synchronous reset clears parser state, the length table and the flags word.
// s_axis_tready drops only when the queue is full behind a stalled output.
// ----------------------------------------------------------------------------
module tlv_attribute_stream_parser
  import tlvp_pkg::*;
#(
  parameter int KNOWN_IDS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] start_list
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] attr_id, [23:16] value_byte, [39:24] byte_offset,
  // [55:40] record_length, [56] known_id, [88:57] flags_word, [95:89] zero
  output logic [95:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_record
);

  localparam int REQ_W = $bits(req_t);

  req_t             front_req;
  logic             front_valid;
  logic             front_ready;
  logic [REQ_W-1:0] q_data;
  logic             q_valid;
  logic             q_ready;
  result_t          res;

  tlvp_front #(
    .KNOWN_IDS (KNOWN_IDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .start_list (s_axis_tuser),
    .req_valid  (front_valid),
    .req_ready  (front_ready),
    .req        (front_req)
  );

  tlvp_fifo #(
    .WIDTH (REQ_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  tlvp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req       (req_t'(q_data)),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {7'd0, res.flags_word, res.known, res.record_length,
                         res.byte_offset, res.value_byte, res.attr_id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the attribute stream parser. A short table of
// directed bytes comes first, then random attribute lists, mostly well formed
// with random content, the rest noise and lists cut short by a fresh start.
// A behavioral parser or the table gives each result; the output stream
// is compared in order. Sender idling and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_top
  import tlvp_pkg::*;
();

  localparam int KNOWN_IDS   = 11;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 1750;
  localparam int NUM_DIR     = 28;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start;
    logic       typed;     // exp below holds the result, else predict it
    result_t    exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] in_byte
  logic        s_axis_tuser;    // [0] start_list
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] attr_id, [23:16] value_byte, [39:24] byte_offset,
  // [55:40] record_length, [56] known_id, [88:57] flags_word, [95:89] zero
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;    // [1:0] kind
  logic        m_axis_tlast;    // last_of_record

  // Parser state as predicted by the bench
  phase_t      prs_phase;
  logic [15:0] prs_id;
  logic [15:0] prs_len;
  logic [15:0] prs_count;
  logic [31:0] prs_flags;
  logic        prs_done;

  result_t     pending_q[$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          fed_count   = 0;
  int          src_idle_pct  = 0;
  int          sink_stall_pct = 0;

  stim_row_t dir_rows [NUM_DIR] = '{
    // id 1, length 1, sent before any start
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{KIND_HEADER, 16'h0001, 8'h00, 16'h0000, 1'b0, 16'h0001, 1'b1, 32'h0}},
    '{8'hFF, 1'b0, 1'b0, '0},
    // fresh list: flags record of five bytes
    '{8'h06, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{KIND_HEADER, 16'h0006, 8'h00, 16'h0000, 1'b0, 16'h0005, 1'b1, 32'h0}},
    '{8'h11, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'h44, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    // unknown id, its value byte is dropped
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{KIND_HEADER, 16'hFFFF, 8'h00, 16'h0000, 1'b0, 16'h0001, 1'b0, 32'h44332211}},
    '{8'h80, 1'b0, 1'b0, '0},
    // zero length record
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{KIND_HEADER, 16'h000A, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, 32'h44332211}},
    // end of list with the largest length, then an ignored byte
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1,
      '{KIND_END, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'hFFFF, 1'b0, 32'h44332211}},
    '{8'h5A, 1'b0, 1'b0, '0}
  };

  tlv_attribute_stream_parser #(
    .KNOWN_IDS(KNOWN_IDS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic void clear_parser();
    prs_phase = PH_ID_LO;
    prs_id    = '0;
    prs_len   = '0;
    prs_count = '0;
    prs_flags = '0;
    prs_done  = 1'b0;
  endfunction

  function automatic result_t make_result(logic [1:0] kind, logic [7:0] vb,
                                          logic [15:0] off, logic last, logic known);
    result_t r;
    r.kind          = kind;
    r.attr_id       = prs_id;
    r.value_byte    = vb;
    r.byte_offset   = off;
    r.last          = last;
    r.record_length = prs_len;
    r.known         = known;
    r.flags_word    = prs_flags;
    return r;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                    output result_t r);
    logic        known;
    logic        last;
    logic        ready;
    logic [15:0] off;
    r = '0;
    if (st) clear_parser();
    if (prs_done) return 1'b0;
    case (prs_phase)
      PH_ID_HI: begin
        prs_id[15:8] = b;
        prs_phase = PH_LEN_LO;
        return 1'b0;
      end
      PH_LEN_LO: begin
        prs_len = {8'h00, b};
        prs_phase = PH_LEN_HI;
        return 1'b0;
      end
      PH_LEN_HI: begin
        prs_len[15:8] = b;
        prs_count = '0;
        if (prs_id == 16'h0000) begin
          prs_done = 1'b1;
          prs_phase = PH_ID_LO;
          r = make_result(KIND_END, 8'h00, 16'h0000, 1'b0, 1'b0);
          return 1'b1;
        end
        known = (prs_id >= 1) && (prs_id < KNOWN_IDS);
        if (prs_id == FLAGS_ID && prs_len != 0) prs_flags = '0;
        prs_phase = (prs_len != 0) ? PH_VALUE : PH_ID_LO;
        r = make_result(KIND_HEADER, 8'h00, 16'h0000, 1'b0, known);
        return 1'b1;
      end
      PH_VALUE: begin
        off   = prs_count;
        last  = (32'(off) + 32'd1) >= 32'(prs_len);
        ready = 1'b0;
        if (prs_id == FLAGS_ID && off < 4) begin
          prs_flags = prs_flags | (32'(b) << (8 * off));
          ready = (off == 3) || last;
        end
        prs_count = prs_count + 16'd1;
        if (last) prs_phase = PH_ID_LO;
        if (!((prs_id >= 1) && (prs_id < KNOWN_IDS))) return 1'b0;
        r = make_result(ready ? KIND_FLAGS : KIND_VALUE, b, off, last, 1'b1);
        return 1'b1;
      end
      default: begin
        prs_id = {8'h00, b};
        prs_phase = PH_ID_HI;
        return 1'b0;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [7:0] b, input logic st,
                           input logic typed, input result_t typed_res);
    result_t r;
    bit      has;
    bit      ignored;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    ignored = prs_done && !st;
    has = parse_byte(b, st, r);
    if (typed) pending_q.push_back(typed_res);
    else if (has) pending_q.push_back(r);
    if (!ignored) fed_count++;
    @(negedge clk);
  endtask

  task automatic send_random_list();
    logic [7:0]  list_q[$];
    logic [15:0] rid;
    logic [15:0] rlen;
    int          pick;
    if ($urandom_range(9) == 0) begin
      // noise
      repeat ($urandom_range(1, 24)) list_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(99);
        if (pick < 25) rid = FLAGS_ID;
        else if (pick < 80) rid = 16'($urandom_range(1, KNOWN_IDS - 1));
        else rid = 16'($urandom_range(KNOWN_IDS, 16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 75) rlen = 16'($urandom_range(0, 6));
        else if (pick < 97) rlen = 16'($urandom_range(7, 40));
        else rlen = 16'($urandom_range(250, 300));
        list_q.push_back(rid[7:0]);
        list_q.push_back(rid[15:8]);
        list_q.push_back(rlen[7:0]);
        list_q.push_back(rlen[15:8]);
        repeat (rlen) list_q.push_back(8'($urandom));
      end
      // most lists close with id 0; the rest get cut off by the next start
      if ($urandom_range(9) != 0) begin
        rlen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        list_q.push_back(8'h00);
        list_q.push_back(8'h00);
        list_q.push_back(rlen[7:0]);
        list_q.push_back(rlen[15:8]);
        repeat ($urandom_range(0, 4)) list_q.push_back(8'($urandom));
      end
    end
    foreach (list_q[i])
      push_byte(list_q[i], (i == 0) || ($urandom_range(63) == 0), 1'b0, '0);
  endtask

  // Receiver side
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL tlv_attribute_stream_parser");
      $finish;
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t act;
    result_t exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act.kind          = m_axis_tuser;
      act.attr_id       = m_axis_tdata[15:0];
      act.value_byte    = m_axis_tdata[23:16];
      act.byte_offset   = m_axis_tdata[39:24];
      act.last          = m_axis_tlast;
      act.record_length = m_axis_tdata[55:40];
      act.known         = m_axis_tdata[56];
      act.flags_word    = m_axis_tdata[88:57];
      if (pending_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: kind %0d id %h byte %h off %0d", act.kind,
                   act.attr_id, act.value_byte, act.byte_offset);
      end else begin
        exp = pending_q.pop_front();
        if (act !== exp) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch exp kind %0d id %h byte %h off %0d last %b len %0d ",
                      "known %b flags %h / got %0d %h %h %0d %b %0d %b %h"},
                     exp.kind, exp.attr_id, exp.value_byte, exp.byte_offset, exp.last,
                     exp.record_length, exp.known, exp.flags_word,
                     act.kind, act.attr_id, act.value_byte, act.byte_offset, act.last,
                     act.record_length, act.known, act.flags_word);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    clear_parser();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      push_byte(dir_rows[i].in_byte, dir_rows[i].start, dir_rows[i].typed,
                dir_rows[i].exp);

    // idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = (ph == 1) ? 63 : (ph == 3) ? 12 : 0;
      sink_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 12 : 0;
      while (fed_count < NUM_DIR + (ph + 1) * (ITEM_TARGET / 4))
        send_random_list();
    end
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("PASS tlv_attribute_stream_parser");
    end else begin
      $display("FAIL tlv_attribute_stream_parser");
    end
    $finish;
  end

endmodule

[tlv_attribute_stream_parser.f]
rtl/tlvp_pkg.sv
rtl/tlvp_fifo.sv
rtl/tlvp_front.sv
rtl/tlvp_back.sv
rtl/tlv_attribute_stream_parser.sv
tb/tb_top.sv
